// ===== rtl/sfm_pkg.sv =====
`default_nettype none
package sfm_pkg;

  localparam logic [16:0] DUTY_BASE  = 17'd42729;
  localparam logic [16:0] DUTY_TERM  = 17'd67729;
  localparam logic [15:0] CENTER     = 16'd32767;

  localparam logic [15:0] RST_THR_FS_LEVEL  = 16'd15000;
  localparam logic [15:0] RST_TO_EXT_LEVEL  = 16'd20000;
  localparam logic [15:0] RST_TO_INT_LEVEL  = 16'd40000;
  localparam logic [7:0]  RST_TRANS_COUNT   = 8'd5;
  localparam logic [15:0] RST_TRIM_TICKS    = 16'd5000;
  localparam logic [15:0] RST_INT_MISS_LIM  = 16'd50;
  localparam logic [15:0] RST_EXT_MISS_LIM  = 16'd1500;

  typedef enum logic [2:0] {
    CFG_THROTTLE_FAILSAFE_LEVEL = 3'd0,
    CFG_TO_EXTERNAL_LEVEL       = 3'd1,
    CFG_TO_INTERNAL_LEVEL       = 3'd2,
    CFG_TRANSITION_COUNT        = 3'd3,
    CFG_TRIM_TRACK_TICKS        = 3'd4,
    CFG_INTERNAL_MISS_LIMIT     = 3'd5,
    CFG_EXTERNAL_MISS_LIMIT     = 3'd6
  } sfm_cfg_idx_t;

  typedef struct packed {
    logic [15:0] rc_throttle;
    logic [15:0] rc_axis1;
    logic [15:0] rc_axis2;
    logic [15:0] rc_mode_switch;
    logic        setpoint_valid;
    logic [15:0] sp_throttle;
    logic [15:0] sp_axis1;
    logic [15:0] sp_axis2;
  } sfm_item_t;

  typedef struct packed {
    logic [16:0] duty_throttle;
    logic [16:0] duty_axis1;
    logic [16:0] duty_axis2;
    logic [15:0] pos_throttle;
    logic [15:0] pos_axis1;
    logic [15:0] pos_axis2;
    logic        internal_mode;
    logic        terminated;
  } sfm_result_t;

  // move a quarter of the way toward the input, rounding toward minus infinity
  function automatic logic [15:0] track_trim(input logic [15:0] trim, input logic [15:0] in);
    logic signed [16:0] diff;
    logic signed [16:0] step;
    logic [16:0]        sum;
    diff = $signed({1'b0, in}) - $signed({1'b0, trim});
    step = diff >>> 2;
    sum  = {1'b0, trim} + $unsigned(step);
    return sum[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sfm_in_if.sv =====
`default_nettype none
interface sfm_in_if import sfm_pkg::*; ();
  logic      valid;
  logic      ready;
  sfm_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/sfm_out_if.sv =====
`default_nettype none
interface sfm_out_if import sfm_pkg::*; ();
  logic        valid;
  logic        ready;
  sfm_result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/servo_failsafe_mode_selector.sv =====
// Servo failsafe mode selector.
// in_ch carries one tick: four measured R/C values and an optional setpoint.
// out_ch carries one result beat per tick: three pulse compare values, the
// logged positions, the control mode before any toggle and the termination
// flag. The cfg_ port writes one of seven threshold/count registers per cycle.
// The user writes them only while the block is idle; the block does not enforce
// this; there is no read-back. A tick's result appears in the cycle after its beat.
// Throughput: one tick per cycle while out_ch does not stall; all state updates
// are done in a single combinational pass from the input beat into the state and
// result registers. The output register decouples the channels: in_ch is ready
// while the output register is empty or its result is taken in the same cycle.
// While out_ch stalls with a result held, in_ch.ready drops; the held result stays put.
// Reset (rst_n low, synchronous) restores the register defaults, selects
// external mode, clears counters, trims and held outputs, releases any
// termination latch and empties the output register.
`default_nettype none
module servo_failsafe_mode_selector import sfm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sfm_in_if.sink     in_ch,
  sfm_out_if.source  out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [15:0] cfg_wdata
);

  logic [15:0] thr_fs_level_r, to_ext_level_r, to_int_level_r;
  logic [7:0]  trans_count_r;
  logic [15:0] trim_ticks_r, int_miss_lim_r, ext_miss_lim_r;

  logic        mode_r, mode_nxt;
  logic        term_r, term_nxt;
  logic [7:0]  trans_ticks_r, trans_ticks_nxt;
  logic [15:0] miss_int_r, miss_int_nxt;
  logic [15:0] miss_ext_r, miss_ext_nxt;
  logic [15:0] trim_done_r, trim_done_nxt;
  logic [15:0] trim0_r, trim0_nxt, trim1_r, trim1_nxt;
  logic [15:0] held0_r, held0_nxt, held1_r, held1_nxt, held2_r, held2_nxt;

  logic        out_valid_r;
  sfm_result_t out_data_r, res_nxt;
  logic        acc;
  logic        trip;
  sfm_item_t   it;

  assign it            = in_ch.data;
  assign in_ch.ready   = !out_valid_r || out_ch.ready;
  assign acc           = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_fs_level_r <= RST_THR_FS_LEVEL;
      to_ext_level_r <= RST_TO_EXT_LEVEL;
      to_int_level_r <= RST_TO_INT_LEVEL;
      trans_count_r  <= RST_TRANS_COUNT;
      trim_ticks_r   <= RST_TRIM_TICKS;
      int_miss_lim_r <= RST_INT_MISS_LIM;
      ext_miss_lim_r <= RST_EXT_MISS_LIM;
    end else if (cfg_we) begin
      unique case (sfm_cfg_idx_t'(cfg_idx))
        CFG_THROTTLE_FAILSAFE_LEVEL: thr_fs_level_r <= cfg_wdata;
        CFG_TO_EXTERNAL_LEVEL:       to_ext_level_r <= cfg_wdata;
        CFG_TO_INTERNAL_LEVEL:       to_int_level_r <= cfg_wdata;
        CFG_TRANSITION_COUNT:        trans_count_r  <= cfg_wdata[7:0];
        CFG_TRIM_TRACK_TICKS:        trim_ticks_r   <= cfg_wdata;
        CFG_INTERNAL_MISS_LIMIT:     int_miss_lim_r <= cfg_wdata;
        CFG_EXTERNAL_MISS_LIMIT:     ext_miss_lim_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_nxt        = mode_r;
    term_nxt        = term_r;
    trans_ticks_nxt = trans_ticks_r;
    miss_int_nxt    = miss_int_r;
    miss_ext_nxt    = miss_ext_r;
    trim_done_nxt   = trim_done_r;
    trim0_nxt       = trim0_r;
    trim1_nxt       = trim1_r;
    held0_nxt       = held0_r;
    held1_nxt       = held1_r;
    held2_nxt       = held2_r;
    trip            = 1'b0;

    res_nxt.duty_throttle = DUTY_BASE;
    res_nxt.duty_axis1    = DUTY_TERM;
    res_nxt.duty_axis2    = DUTY_TERM;
    res_nxt.pos_throttle  = '0;
    res_nxt.pos_axis1     = '0;
    res_nxt.pos_axis2     = '0;
    res_nxt.internal_mode = mode_r;
    res_nxt.terminated    = 1'b1;

    if (!term_r) begin
      if (mode_r) begin
        if (it.setpoint_valid) begin
          held0_nxt    = it.sp_throttle;
          held1_nxt    = trim0_r - CENTER + it.sp_axis1;
          held2_nxt    = trim1_r - CENTER + ~it.sp_axis2;
          miss_int_nxt = '0;
        end else if (miss_int_r != 16'hFFFF) begin
          miss_int_nxt = miss_int_r + 16'd1;
        end
        if (it.rc_mode_switch < to_ext_level_r) begin
          trans_ticks_nxt = (trans_ticks_r == 8'hFF) ? trans_ticks_r : trans_ticks_r + 8'd1;
        end else begin
          trans_ticks_nxt = '0;
        end
        trip = miss_int_nxt > int_miss_lim_r;
      end else begin
        held0_nxt = it.rc_throttle;
        held1_nxt = it.rc_axis1;
        held2_nxt = it.rc_axis2;
        if (it.rc_mode_switch > to_int_level_r) begin
          if (it.rc_throttle < thr_fs_level_r) begin
            miss_ext_nxt    = (miss_ext_r == 16'hFFFF) ? miss_ext_r : miss_ext_r + 16'd1;
            trans_ticks_nxt = '0;
          end else begin
            trans_ticks_nxt = (trans_ticks_r == 8'hFF) ? trans_ticks_r : trans_ticks_r + 8'd1;
            miss_ext_nxt    = '0;
          end
        end else begin
          trans_ticks_nxt = '0;
          miss_ext_nxt    = '0;
        end
        trip = miss_ext_nxt > ext_miss_lim_r;
      end

      if (trip) begin
        term_nxt = 1'b1;
      end else begin
        if (trim_done_r < trim_ticks_r) begin
          trim0_nxt     = track_trim(trim0_r, it.rc_axis1);
          trim1_nxt     = track_trim(trim1_r, it.rc_axis2);
          trim_done_nxt = trim_done_r + 16'd1;
        end
        res_nxt.duty_throttle = {1'b0, held0_nxt} + DUTY_BASE;
        res_nxt.duty_axis1    = {1'b0, held1_nxt} + DUTY_BASE;
        res_nxt.duty_axis2    = {1'b0, held2_nxt} + DUTY_BASE;
        res_nxt.pos_throttle  = held0_nxt;
        res_nxt.pos_axis1     = held1_nxt - (trim0_nxt - CENTER);
        res_nxt.pos_axis2     = ~(held2_nxt - (trim1_nxt - CENTER));
        res_nxt.terminated    = 1'b0;
        if (trans_ticks_nxt >= trans_count_r) begin
          mode_nxt = !mode_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= 1'b0;
      term_r        <= 1'b0;
      trans_ticks_r <= '0;
      miss_int_r    <= '0;
      miss_ext_r    <= '0;
      trim_done_r   <= '0;
      trim0_r       <= '0;
      trim1_r       <= '0;
      held0_r       <= '0;
      held1_r       <= '0;
      held2_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (acc) begin
        mode_r        <= mode_nxt;
        term_r        <= term_nxt;
        trans_ticks_r <= trans_ticks_nxt;
        miss_int_r    <= miss_int_nxt;
        miss_ext_r    <= miss_ext_nxt;
        trim_done_r   <= trim_done_nxt;
        trim0_r       <= trim0_nxt;
        trim1_r       <= trim1_nxt;
        held0_r       <= held0_nxt;
        held1_r       <= held1_nxt;
        held2_r       <= held2_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= res_nxt;
    end
  end

  a_term_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    term_r |=> term_r)
    else $error("termination latch released");

  a_term_output: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && term_r) |=> (out_data_r.terminated && out_data_r.duty_throttle == DUTY_BASE
                         && out_data_r.pos_axis2 == 16'd0))
    else $error("terminated tick gave live outputs");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> ($stable(mode_r) && $stable(term_r) && $stable(trim_done_r)))
    else $error("state changed without an input beat");

  a_mode_report: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (out_valid_r && out_data_r.internal_mode == $past(mode_r)))
    else $error("result mode differs from mode held at the beat");

endmodule
`default_nettype wire
